// ===== rtl/core/biou_pkg.sv =====
package biou_pkg;

  // Areas are kept at four times the true scale because the edges are doubled.
  localparam int AREA_SHIFT = 2;

  // Sideband that travels with each word through the divider.
  typedef struct packed {
    logic vld;
    logic uzero;
  } biou_ctl_t;

endpackage

// ===== rtl/core/biou_div_pipe.sv =====
module biou_div_pipe #(
  parameter int QW = 17,
  parameter int DW = 37
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  biou_pkg::biou_ctl_t   in_ctl,
  input  logic [DW-1:0]         in_num,
  input  logic [DW-1:0]         in_den,
  output biou_pkg::biou_ctl_t   out_ctl,
  output logic [QW-1:0]         out_quo
);
  import biou_pkg::*;

  // One restoring step per stage; the numerator never exceeds the denominator,
  // so the first stage yields the integer bit and each later stage one fraction bit.
  logic [DW-1:0] rem_r   [QW];
  logic [DW-1:0] rem_nxt [QW];
  logic [DW-1:0] den_r   [QW];
  logic [DW-1:0] sden    [QW];
  logic [QW-1:0] quo_r   [QW];
  logic [QW-1:0] quo_nxt [QW];
  logic [QW-1:0] squo    [QW];
  logic [DW:0]   part    [QW];
  logic [DW:0]   diff    [QW];
  logic          take    [QW];
  biou_ctl_t     ctl_r   [QW];

  always_comb begin
    part[0] = {1'b0, in_num};
    sden[0] = in_den;
    squo[0] = '0;
    for (int k = 1; k < QW; k++) begin
      part[k] = {rem_r[k-1], 1'b0};
      sden[k] = den_r[k-1];
      squo[k] = quo_r[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      take[k]    = part[k] >= {1'b0, sden[k]};
      diff[k]    = part[k] - {1'b0, sden[k]};
      rem_nxt[k] = take[k] ? diff[k][DW-1:0] : part[k][DW-1:0];
      quo_nxt[k] = {squo[k][QW-2:0], take[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) begin
        ctl_r[k].vld <= 1'b0;
      end
    end else begin
      ctl_r[0] <= in_ctl;
      for (int k = 1; k < QW; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      rem_r[k] <= rem_nxt[k];
      den_r[k] <= sden[k];
      quo_r[k] <= quo_nxt[k];
    end
  end

  assign out_ctl = ctl_r[QW-1];
  assign out_quo = quo_r[QW-1];

endmodule

// ===== rtl/core/box_iou_center_format_top.sv =====
// out_valid rises once the word taken with start has passed through four front stages,
// FRAC_BITS+1 divider stages and one output stage.
// Throughput: one word per cycle, set by the fully pipelined restoring divider.
// busy never rises, since the receiver cannot stall and no stage ever waits.
// Reset is synchronous and active low; it clears every valid bit, so no result
// strobe follows reset until a new word has been taken.
module box_iou_center_format_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [FRAC_BITS:0]   in_a_cx,
  input  logic [FRAC_BITS:0]   in_a_cy,
  input  logic [FRAC_BITS:0]   in_a_wd,
  input  logic [FRAC_BITS:0]   in_a_ht,
  input  logic [FRAC_BITS:0]   in_b_cx,
  input  logic [FRAC_BITS:0]   in_b_cy,
  input  logic [FRAC_BITS:0]   in_b_wd,
  input  logic [FRAC_BITS:0]   in_b_ht,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   out_iou,
  output logic                 out_union_zero
);
  import biou_pkg::*;

  // W is the field width, EW a signed doubled edge, PW one product of two fields,
  // IW the product of two non-negative doubled overlaps, DW the scaled union.
  localparam int W   = FRAC_BITS + 1;
  localparam int EW  = W + 3;
  localparam int PW  = 2 * W;
  localparam int IW  = 2 * W + 2;
  localparam int DW  = 2 * W + 1 + AREA_SHIFT;
  // LAT counts edges from the one that takes a word to the one that takes its result,
  // which is the edge after the strobe rises.
  localparam int LAT = FRAC_BITS + 6;

  // The pipeline never stalls, so a word is taken whenever start is high.
  assign busy = 1'b0;

  // Stage 1: register the incoming word.
  logic         v1_r;
  logic [W-1:0] acx_r, acy_r, awd_r, aht_r, bcx_r, bcy_r, bwd_r, bht_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    acx_r <= in_a_cx;
    acy_r <= in_a_cy;
    awd_r <= in_a_wd;
    aht_r <= in_a_ht;
    bcx_r <= in_b_cx;
    bcy_r <= in_b_cy;
    bwd_r <= in_b_wd;
    bht_r <= in_b_ht;
  end

  // Stage 2: doubled overlap on each axis, and the two box areas.
  // Edges are 2c - w and 2c + w, which keeps everything exact in integers.
  function automatic logic signed [EW-1:0] overlap2(
    input logic [W-1:0] c1, input logic [W-1:0] w1,
    input logic [W-1:0] c2, input logic [W-1:0] w2
  );
    logic signed [EW-1:0] l1, l2, r1, r2, lo, hi;
    l1 = $signed({2'b00, c1, 1'b0}) - $signed({3'b000, w1});
    l2 = $signed({2'b00, c2, 1'b0}) - $signed({3'b000, w2});
    r1 = $signed({2'b00, c1, 1'b0}) + $signed({3'b000, w1});
    r2 = $signed({2'b00, c2, 1'b0}) + $signed({3'b000, w2});
    lo = (l1 > l2) ? l1 : l2;
    hi = (r1 < r2) ? r1 : r2;
    return hi - lo;
  endfunction

  logic                 v2_r;
  logic signed [EW-1:0] ow_r, oh_r, ow_nxt, oh_nxt;
  logic [PW-1:0]        pa_r, pb_r, pa_nxt, pb_nxt;

  always_comb begin
    ow_nxt = overlap2(acx_r, awd_r, bcx_r, bwd_r);
    oh_nxt = overlap2(acy_r, aht_r, bcy_r, bht_r);
    pa_nxt = PW'(awd_r) * PW'(aht_r);
    pb_nxt = PW'(bwd_r) * PW'(bht_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    ow_r <= ow_nxt;
    oh_r <= oh_nxt;
    pa_r <= pa_nxt;
    pb_r <= pb_nxt;
  end

  // Stage 3: intersection and summed areas, both at four times true scale.
  // A non-negative doubled overlap is at most twice a width, so W+1 bits hold it.
  // A negative overlap on either axis means the boxes do not meet at all.
  logic          v3_r;
  logic          meet;
  logic [IW-1:0] inter_r, inter_nxt;
  logic [DW-1:0] area_r, area_nxt;

  always_comb begin
    meet      = !ow_r[EW-1] && !oh_r[EW-1];
    inter_nxt = meet ? (IW'(ow_r[W:0]) * IW'(oh_r[W:0])) : '0;
    area_nxt  = DW'((PW+1)'(pa_r) + (PW+1)'(pb_r)) << AREA_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    inter_r <= inter_nxt;
    area_r  <= area_nxt;
  end

  // Stage 4: union. The intersection never exceeds either scaled area,
  // so the subtraction cannot wrap.
  biou_ctl_t     ctl4_r;
  logic [DW-1:0] num_r, den_r, den_nxt;

  assign den_nxt = area_r - DW'(inter_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r.vld <= 1'b0;
    end else begin
      ctl4_r.vld   <= v3_r;
      ctl4_r.uzero <= (den_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    num_r <= DW'(inter_r);
    den_r <= den_nxt;
  end

  // Divider stages: floor(inter * 2^FRAC_BITS / union), one bit per stage.
  biou_ctl_t    div_ctl;
  logic [W-1:0] div_quo;

  biou_div_pipe #(
    .QW (W),
    .DW (DW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (ctl4_r),
    .in_num  (num_r),
    .in_den  (den_r),
    .out_ctl (div_ctl),
    .out_quo (div_quo)
  );

  // Output stage: an empty union forces the ratio to zero and raises the flag.
  logic         out_valid_r;
  logic         out_union_zero_r;
  logic [W-1:0] out_iou_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_union_zero_r <= div_ctl.uzero;
    out_iou_r        <= div_ctl.uzero ? '0 : div_quo;
  end

  assign out_valid      = out_valid_r;
  assign out_iou        = out_iou_r;
  assign out_union_zero = out_union_zero_r;

  // Every word taken produces its result strobe a fixed number of edges later.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result strobe missing at the expected latency");

  // A strobe only appears for a word that was actually taken.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result strobe without a matching word");

  // The ratio never exceeds 1.0 and is zero whenever the union is empty.
  a_iou_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_iou <= (W'(1) << FRAC_BITS)) &&
                  (!out_union_zero || (out_iou == '0)))
    else $error("ratio out of range or nonzero for an empty union");

endmodule

// ===== test/box_iou_center_format_top_tb.sv =====
module box_iou_center_format_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import biou_pkg::*;

  // The block is checked at its default precision. Every field is one bit wider than the
  // fraction, so Q1.16 inputs and a Q1.16 ratio that can reach exactly 1.0.
  localparam int FB   = 16;
  localparam int W    = FB + 1;
  localparam int ONE  = 1 << FB;
  localparam int MAXV = (1 << W) - 1;

  // Just short of the pipeline depth, used by the drain wait at the end, which waits longer still.
  localparam int PIPE_DEPTH = FB + 5;

  typedef struct packed {
    logic [FB:0] cx;
    logic [FB:0] cy;
    logic [FB:0] wd;
    logic [FB:0] ht;
  } box_t;

  typedef struct packed {
    logic [FB:0] iou;
    logic        union_zero;
  } iou_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [FB:0] in_a_cx = '0;
  logic [FB:0] in_a_cy = '0;
  logic [FB:0] in_a_wd = '0;
  logic [FB:0] in_a_ht = '0;
  logic [FB:0] in_b_cx = '0;
  logic [FB:0] in_b_cy = '0;
  logic [FB:0] in_b_wd = '0;
  logic [FB:0] in_b_ht = '0;
  logic        out_valid;
  logic [FB:0] out_iou;
  logic        out_union_zero;

  // Ratios that the block still owes, oldest first. Each accepted pair of boxes adds exactly one entry.
  iou_word_t iou_pending[$];

  int fail_count = 0;
  int pairs_sent = 0;
  int ratios_seen = 0;
  int zero_union_seen = 0;
  int full_overlap_seen = 0;
  int disjoint_seen = 0;

  // When set, words go back to back with no idle cycles between them.
  bit back_to_back = 1'b0;

  box_iou_center_format_top #(
    .FRAC_BITS(FB)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_a_cx       (in_a_cx),
    .in_a_cy       (in_a_cy),
    .in_a_wd       (in_a_wd),
    .in_a_ht       (in_a_ht),
    .in_b_cx       (in_b_cx),
    .in_b_cy       (in_b_cy),
    .in_b_wd       (in_b_wd),
    .in_b_ht       (in_b_ht),
    .out_valid     (out_valid),
    .out_iou       (out_iou),
    .out_union_zero(out_union_zero)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // This returns the overlap of two spans at doubled scale. Each edge is 2*center -/+ width,
  // so no half bit is ever lost. A negative value means that the spans are apart.
  function automatic longint span_overlap2(longint c1, longint w1, longint c2, longint w2);
    longint lo;
    longint hi;
    lo = (2 * c1 - w1 > 2 * c2 - w2) ? 2 * c1 - w1 : 2 * c2 - w2;
    hi = (2 * c1 + w1 < 2 * c2 + w2) ? 2 * c1 + w1 : 2 * c2 + w2;
    return hi - lo;
  endfunction

  // The intersection and the union are both held at four times the true area, so the
  // factor cancels in the ratio. The intersection is at most the union, well below 2^38,
  // so shifted up by FB bits it fits in 64 bits; one divide gives the truncated quotient.
  function automatic iou_word_t iou_predict(box_t a, box_t b);
    longint            ow;
    longint            oh;
    longint unsigned   inter;
    longint unsigned   area_a;
    longint unsigned   area_b;
    longint unsigned   uni;
    iou_word_t         r;
    ow = span_overlap2(a.cx, a.wd, b.cx, b.wd);
    oh = span_overlap2(a.cy, a.ht, b.cy, b.ht);
    inter = 0;
    if (ow >= 0 && oh >= 0) begin
      inter = longint'(ow) * longint'(oh);
    end
    area_a = a.wd;
    area_a = area_a * a.ht;
    area_b = b.wd;
    area_b = area_b * b.ht;
    uni = ((area_a + area_b) << AREA_SHIFT) - inter;
    if (uni == 0) begin
      r.iou = '0;
      r.union_zero = 1'b1;
    end else begin
      r.iou = W'((inter << FB) / uni);
      r.union_zero = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------------------

  // The receiver cannot hold results off, so every cycle with out_valid high carries one
  // word that is taken at the edge that ends it. Sampling at that edge reads the values
  // the block drove during the cycle. A strobe that is X is treated as a result as well,
  // so that it gets reported instead of slipping by.
  always @(posedge clk) begin
    iou_word_t want;
    if (rst_n && out_valid !== 1'b0) begin
      ratios_seen++;
      if (iou_pending.size() == 0) begin
        $display("%0t: result with none expected: iou %0d union_zero %0b",
                 $time, out_iou, out_union_zero);
        fail_count++;
      end else begin
        want = iou_pending.pop_front();
        if (out_iou !== want.iou) begin
          $display("%0t: iou mismatch: expected %0d actual %0d", $time, want.iou, out_iou);
          fail_count++;
        end
        if (out_union_zero !== want.union_zero) begin
          $display("%0t: union_zero mismatch: expected %0b actual %0b",
                   $time, want.union_zero, out_union_zero);
          fail_count++;
        end
        if (want.union_zero) begin
          zero_union_seen++;
        end else if (want.iou == ONE) begin
          full_overlap_seen++;
        end else if (want.iou == 0) begin
          disjoint_seen++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  function automatic box_t mk_box(int cx, int cy, int wd, int ht);
    box_t bx;
    bx.cx = W'(cx);
    bx.cy = W'(cy);
    bx.wd = W'(wd);
    bx.ht = W'(ht);
    return bx;
  endfunction

  function automatic int clamp_field(int v);
    return (v < 0) ? 0 : ((v > MAXV) ? MAXV : v);
  endfunction

  // Most values lie in the nominal range 0 to 1.0. A few sit on the extremes, and a few
  // go above 1.0, which the block must take as plain numbers.
  function automatic int pick_coord();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 88) begin
      return $urandom_range(0, ONE);
    end else if (sel < 94) begin
      case ($urandom_range(0, 2))
        0: return 0;
        1: return ONE;
        default: return MAXV;
      endcase
    end
    return $urandom_range(ONE, MAXV);
  endfunction

  // Most gaps are zero or short. Now and then a long one lets the pipeline run
  // partly or wholly empty, so that idle cycles fall on every stage of the divider.
  task automatic idle_after_word();
    int sel;
    int gap;
    sel = $urandom_range(0, 99);
    if (back_to_back || sel < 55) begin
      gap = 0;
    end else if (sel < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // This sends one pair of boxes and records the ratio expected for it. The word is taken
  // at the first edge that sees start high and busy low. start is not lowered when the
  // next word follows at once, so it never gets two assignments in one step.
  task automatic send_pair(box_t a, box_t b);
    start   <= 1'b1;
    in_a_cx <= a.cx;
    in_a_cy <= a.cy;
    in_a_wd <= a.wd;
    in_a_ht <= a.ht;
    in_b_cx <= b.cx;
    in_b_cy <= b.cy;
    in_b_wd <= b.wd;
    in_b_ht <= b.ht;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    iou_pending.push_back(iou_predict(a, b));
    pairs_sent++;
    idle_after_word();
  endtask

  // Every 50 words the gaps are switched off for a stretch, with a chance of one in four.
  task automatic maybe_toggle_burst(int n);
    if (n % 50 == 0) begin
      back_to_back = ($urandom_range(0, 3) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Hand-picked pairs: the field extremes, identical boxes, boxes that are apart, boxes
  // that just touch, nested boxes, boxes with no area and values above 1.0.
  task automatic test_directed();
    int h;
    h = ONE / 2;
    // Both boxes have no area, so the union is zero and the flag must rise.
    send_pair(mk_box(0, 0, 0, 0), mk_box(0, 0, 0, 0));
    // Every bit of every field set: identical boxes give a ratio of exactly 1.0.
    send_pair(mk_box(MAXV, MAXV, MAXV, MAXV), mk_box(MAXV, MAXV, MAXV, MAXV));
    send_pair(mk_box(h, h, ONE, ONE), mk_box(h, h, ONE, ONE));
    // Apart on x only, then apart on y only.
    send_pair(mk_box(ONE / 8, h, ONE / 8, ONE / 4), mk_box(ONE - ONE / 8, h, ONE / 8, ONE / 4));
    send_pair(mk_box(h, ONE / 8, ONE / 4, ONE / 8), mk_box(h, ONE - ONE / 8, ONE / 4, ONE / 8));
    // Touching on x, then on y: the overlap is exactly zero, so the ratio is zero.
    send_pair(mk_box(ONE / 4, h, h, h), mk_box(3 * ONE / 4, h, h, h));
    send_pair(mk_box(h, ONE / 4, h, h), mk_box(h, 3 * ONE / 4, h, h));
    // One box inside the other, and the same again with the roles swapped.
    send_pair(mk_box(h, h, ONE, ONE), mk_box(h, h, ONE / 4, ONE / 4));
    send_pair(mk_box(h, h, ONE / 4, ONE / 4), mk_box(h, h, ONE, ONE));
    // One box without area next to a full one: the union stays nonzero.
    send_pair(mk_box(h, h, 0, ONE), mk_box(h, h, ONE, ONE));
    send_pair(mk_box(0, 0, 0, 0), mk_box(MAXV, MAXV, MAXV, MAXV));
    // Two flat boxes: zero width in one, zero height in the other, so no area at all.
    send_pair(mk_box(h, h, ONE, 0), mk_box(h, h, 0, ONE));
    send_pair(mk_box(h, h, 0, ONE), mk_box(h, h, 0, ONE));
    // Centers at zero with wide boxes push the left edges below zero.
    send_pair(mk_box(0, 0, ONE, ONE), mk_box(0, 0, MAXV, ONE / 2));
    // Partial overlap, half a box shifted along the diagonal.
    send_pair(mk_box(h, h, h, h), mk_box(h + ONE / 4, h + ONE / 4, h, h));
    // The smallest nonzero boxes, first overlapping, then with centers one step apart, so they just touch.
    send_pair(mk_box(1, 1, 1, 1), mk_box(1, 1, 1, 1));
    send_pair(mk_box(1, 1, 1, 1), mk_box(2, 1, 1, 1));
    // Values above 1.0 on one side only, and an off-by-one from full overlap.
    send_pair(mk_box(MAXV, ONE + 5, MAXV, ONE + 9), mk_box(ONE, ONE, ONE / 3, ONE / 7));
    send_pair(mk_box(h, h, ONE, ONE), mk_box(h, h, ONE - 1, ONE));
    send_pair(mk_box(ONE, 0, 1, MAXV), mk_box(0, ONE, MAXV, 1));
  endtask

  // Pairs that mostly overlap, since that is where the divide does real work. The second
  // center is put within reach of the first so that the spans mostly meet on both axes.
  task automatic test_overlapping_pairs(int count);
    box_t a;
    box_t b;
    int   reach;
    for (int n = 0; n < count; n++) begin
      maybe_toggle_burst(n);
      a = mk_box(pick_coord(), pick_coord(), pick_coord(), pick_coord());
      b = mk_box(0, 0, pick_coord(), pick_coord());
      reach = (int'(a.wd) + int'(b.wd)) / 2 + 1;
      b.cx = W'(clamp_field(int'(a.cx) + $urandom_range(0, 2 * reach) - reach));
      reach = (int'(a.ht) + int'(b.ht)) / 2 + 1;
      b.cy = W'(clamp_field(int'(a.cy) + $urandom_range(0, 2 * reach) - reach));
      case ($urandom_range(0, 19))
        0: b = a;
        1: begin
          b.cx = a.cx;
          b.cy = a.cy;
        end
        default: ;
      endcase
      if ($urandom_range(0, 1)) begin
        send_pair(a, b);
      end else begin
        send_pair(b, a);
      end
    end
  endtask

  // Every field drawn over its whole width, so each bit takes both values many times.
  task automatic test_full_range(int count);
    for (int n = 0; n < count; n++) begin
      maybe_toggle_burst(n);
      send_pair(mk_box($urandom_range(0, MAXV), $urandom_range(0, MAXV),
                       $urandom_range(0, MAXV), $urandom_range(0, MAXV)),
                mk_box($urandom_range(0, MAXV), $urandom_range(0, MAXV),
                       $urandom_range(0, MAXV), $urandom_range(0, MAXV)));
    end
  endtask

  // Boxes without area, boxes whose edges just touch, identical boxes and boxes nested
  // inside one another, with random positions and sizes.
  task automatic test_degenerate(int count);
    box_t a;
    box_t b;
    for (int n = 0; n < count; n++) begin
      maybe_toggle_burst(n);
      a = mk_box(pick_coord(), pick_coord(), pick_coord(), pick_coord());
      b = mk_box(pick_coord(), pick_coord(), pick_coord(), pick_coord());
      case ($urandom_range(0, 5))
        0: begin
          a.wd = '0;
        end
        1: begin
          // Both boxes flat, so the union is zero wherever they sit.
          if ($urandom_range(0, 1)) a.wd = '0; else a.ht = '0;
          if ($urandom_range(0, 1)) b.wd = '0; else b.ht = '0;
        end
        2: begin
          // Even widths let the second box start exactly where the first one ends.
          a.cx = W'($urandom_range(0, ONE / 2));
          a.wd = W'(2 * $urandom_range(0, ONE / 2));
          b.wd = W'(2 * $urandom_range(0, ONE / 2));
          b.cx = W'(int'(a.cx) + (int'(a.wd) + int'(b.wd)) / 2);
          b.cy = a.cy;
        end
        3: begin
          a.cy = W'($urandom_range(0, ONE / 2));
          a.ht = W'(2 * $urandom_range(0, ONE / 2));
          b.ht = W'(2 * $urandom_range(0, ONE / 2));
          b.cy = W'(int'(a.cy) + (int'(a.ht) + int'(b.ht)) / 2);
          b.cx = a.cx;
        end
        4: begin
          b = a;
        end
        default: begin
          b = a;
          b.wd = W'($urandom_range(0, a.wd));
          b.ht = W'($urandom_range(0, a.ht));
        end
      endcase
      if ($urandom_range(0, 1)) begin
        send_pair(a, b);
      end else begin
        send_pair(b, a);
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    // Reset is held at the start and never asserted again.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_overlapping_pairs(1000);
    test_full_range(350);
    test_degenerate(250);

    start <= 1'b0;
    // Wait for the last ratio, then a little longer than the pipeline depth so that a
    // stray strobe would still be caught.
    while (iou_pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);

    $display("Sent %0d box pairs and checked %0d ratios.", pairs_sent, ratios_seen);
    $display("Among them %0d had an empty union, %0d full overlap and %0d no overlap.",
             zero_union_seen, full_overlap_seen, disjoint_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // The slowest correct run is near 1600 words at the longest gap, well under half a
  // millisecond. This guard sits far beyond that.
  initial begin
    #3_000_000;
    $display("Timed out with %0d ratios still pending.", iou_pending.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
